### rtl/core/hfwa_pkg.sv
// Package: constants, opcodes and state type for the hole-fill block.
package hfwa_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxHeight  = 64;
  localparam int unsigned StoreDepth = 65536;
  localparam int unsigned PixW       = 24;
  localparam int unsigned AddrW      = 16;
  localparam int unsigned SumW       = 16;
  localparam int unsigned CntW       = 8;
  localparam int unsigned DivSteps   = 16;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_HALF_X = 3'd2,
    REG_HALF_Y = 3'd3,
    REG_PASSES = 3'd4,
    REG_COLOR  = 3'd5
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CRD,
    ST_CCHK,
    ST_WIN,
    ST_DRAIN,
    ST_DSTART,
    ST_DIV,
    ST_WR,
    ST_NEXT
  } state_e;

endpackage

### rtl/core/hfwa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
module hfwa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### rtl/core/image_hole_fill_window_average.sv
// Hole fill by window mean over a 64K x 24-bit pixel store.
// A write word is stored on acceptance. A read word passes through ST_READ, where the
// registered store read returns; its result word is registered at the end of ST_READ, and
// the next input word can be taken in the cycle that result word leaves. A run word walks
// pass_count raster passes over the image. Every pixel passes through the centre read
// (ST_CRD, ST_CCHK) and a step state (ST_NEXT). An empty pixel adds one store read per window
// position (the single store read port, centre included), a drain and a divider setup state;
// with filled neighbours it adds the divider (one quotient bit per cycle, three channels in
// parallel) and a write-back state. The done word is registered at the end of the last step.
// The store has no reset; only entries that were written may be read.
module image_hole_fill_window_average (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // pixel_index, in_chan0, in_chan1, in_chan2
  input  logic [1:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // out_chan0, out_chan1, out_chan2
  output logic        m_axis_tuser,  // is_done
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);
  import hfwa_pkg::*;

  // configuration
  logic [10:0] width_q;
  logic [6:0]  height_q;
  logic [2:0]  hx_q, hy_q;
  logic [3:0]  passes_q;
  logic        color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 7'd64;
      hx_q     <= 3'd0;
      hy_q     <= 3'd2;
      passes_q <= 4'd4;
      color_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i[6:0];
        REG_HALF_X: hx_q     <= cfg_data_i[2:0];
        REG_HALF_Y: hy_q     <= cfg_data_i[2:0];
        REG_PASSES: passes_q <= cfg_data_i[3:0];
        REG_COLOR:  color_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // saturated sizes
  logic [10:0] w_eff;
  logic [6:0]  h_eff;
  assign w_eff = (width_q > 11'(MaxWidth)) ? 11'(MaxWidth) : width_q;
  assign h_eff = (height_q > 7'(MaxHeight)) ? 7'(MaxHeight) : height_q;

  // input fields
  op_e         op;
  logic [15:0] in_idx;
  logic        in_acc;
  assign op     = op_e'(s_axis_tuser);
  assign in_idx = s_axis_tdata[15:0];

  // state and counters
  state_e state_q, state_d;
  logic [3:0]  pass_q;
  logic [9:0]  r_q, c_q, y_q, x_q;
  logic [9:0]  xs_q, xe_q, ye_q;
  logic [PixW-1:0] ctr_q;
  logic [SumW-1:0] sum_q [3];
  logic [CntW-1:0] n_q;
  logic        acc_v_q;
  logic [SumW-1:0] num_q [3];
  logic [CntW-1:0] rem_q [3];
  logic [4:0]  dcnt_q;
  logic        out_v_q, out_done_q;
  logic [23:0] out_data_q;

  // store
  logic              we;
  logic [AddrW-1:0]  waddr, raddr, pix_addr;
  logic [PixW-1:0]   wdata, rdata;

  hfwa_ram #(.Width(PixW), .Depth(StoreDepth)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // address of (row, col): one multiply and add, wrapped to 16 bits
  logic [9:0]  row_sel, col_sel;
  logic [20:0] prod;
  assign row_sel  = (state_q == ST_WIN) ? y_q : r_q;
  assign col_sel  = (state_q == ST_WIN) ? x_q : c_q;
  assign prod     = 21'(row_sel) * 21'(w_eff) + 21'(col_sel);
  assign pix_addr = prod[15:0];

  // emptiness tests
  logic ctr_full, rd_full;
  assign rd_full = (rdata[7:0] != 8'd0) ||
                   (color_q && (rdata[23:8] != 16'd0));
  assign ctr_full = rd_full;

  // window bounds of the current pixel
  logic [9:0]  ys_n, ye_n, xs_n, xe_n;
  logic [10:0] ysum, xsum;
  assign ysum = 11'(r_q) + 11'(hy_q);
  assign xsum = 11'(c_q) + 11'(hx_q);
  assign ys_n = (r_q >= 10'(hy_q)) ? r_q - 10'(hy_q) : 10'd0;
  assign xs_n = (c_q >= 10'(hx_q)) ? c_q - 10'(hx_q) : 10'd0;
  assign ye_n = (ysum > 11'(h_eff) - 11'd1) ? 10'(h_eff - 7'd1) : ysum[9:0];
  assign xe_n = (xsum > w_eff - 11'd1) ? 10'(w_eff - 11'd1) : xsum[9:0];

  logic at_center, win_last, row_last, col_last, img_last;
  assign at_center = (y_q == r_q) && (x_q == c_q);
  assign win_last  = (x_q == xe_q) && (y_q == ye_q);
  assign col_last  = (11'(c_q) == w_eff - 11'd1);
  assign row_last  = (7'(r_q) == h_eff - 7'd1);
  assign img_last  = col_last && row_last && (pass_q == passes_q - 4'd1);

  logic run_empty;
  assign run_empty = (w_eff == 11'd0) || (h_eff == 7'd0) || (passes_q == 4'd0);

  logic out_free, out_set;
  assign out_free = !out_v_q || m_axis_tready;
  assign out_set  = (state_q == ST_READ) ||
                    (state_q == ST_IDLE && in_acc && op == OP_RUN && run_empty) ||
                    (state_q == ST_NEXT && img_last);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (op == OP_READ) begin
            state_d = ST_READ;
          end else if (op == OP_RUN && !run_empty) begin
            state_d = ST_CRD;
          end
        end
      end
      ST_READ:   state_d = ST_IDLE;
      ST_CRD:    state_d = ST_CCHK;
      ST_CCHK:   state_d = ctr_full ? ST_NEXT : ST_WIN;
      ST_WIN:    state_d = win_last ? ST_DRAIN : ST_WIN;
      ST_DRAIN:  state_d = ST_DSTART;
      ST_DSTART: state_d = (n_q == '0) ? ST_NEXT : ST_DIV;
      ST_DIV:    state_d = (dcnt_q == 5'(DivSteps - 1)) ? ST_WR : ST_DIV;
      ST_WR:     state_d = ST_NEXT;
      ST_NEXT:   state_d = img_last ? ST_IDLE : ST_CRD;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    s_axis_tready = 1'b0;
    we            = 1'b0;
    waddr         = pix_addr;
    raddr         = pix_addr;
    wdata         = ctr_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = out_free;
        raddr         = in_idx;
        waddr         = in_idx;
        we            = in_acc && (op == OP_WRITE);
        wdata         = s_axis_tdata[39:16];
      end
      ST_WR: begin
        we    = 1'b1;
        wdata = color_q ? {num_q[2][7:0], num_q[1][7:0], num_q[0][7:0]}
                        : {ctr_q[23:8], num_q[0][7:0]};
      end
      default: ;
    endcase
  end

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_v_q <= 1'b0;
      acc_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_v_q <= (state_q == ST_WIN) && !at_center;
      // a new result word wins over the hand-off of the old one
      if (out_set) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (acc_v_q && rd_full) begin
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= sum_q[i] + SumW'(rdata[8*i +: 8]);
      end
      n_q <= n_q + CntW'(1);
    end
    unique case (state_q)
      ST_IDLE: begin
        pass_q <= '0;
        r_q    <= '0;
        c_q    <= '0;
        if (in_acc && op == OP_RUN) begin
          out_data_q <= '0;
          out_done_q <= 1'b1;
        end
      end
      ST_READ: begin
        out_data_q <= color_q ? rdata : {16'd0, rdata[7:0]};
        out_done_q <= 1'b0;
      end
      ST_CCHK: begin
        ctr_q <= rdata;
        y_q   <= ys_n;
        x_q   <= xs_n;
        xs_q  <= xs_n;
        xe_q  <= xe_n;
        ye_q  <= ye_n;
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= '0;
        end
        n_q <= '0;
      end
      ST_WIN: begin
        if (x_q == xe_q) begin
          x_q <= xs_q;
          y_q <= y_q + 10'd1;
        end else begin
          x_q <= x_q + 10'd1;
        end
      end
      ST_DSTART: begin
        dcnt_q <= '0;
        for (int i = 0; i < 3; i++) begin
          num_q[i] <= sum_q[i];
          rem_q[i] <= '0;
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        dcnt_q <= dcnt_q + 5'd1;
        for (int i = 0; i < 3; i++) begin
          if ({rem_q[i], num_q[i][SumW-1]} >= {1'b0, n_q}) begin
            rem_q[i] <= 8'({rem_q[i], num_q[i][SumW-1]} - {1'b0, n_q});
            num_q[i] <= {num_q[i][SumW-2:0], 1'b1};
          end else begin
            rem_q[i] <= {rem_q[i][6:0], num_q[i][SumW-1]};
            num_q[i] <= {num_q[i][SumW-2:0], 1'b0};
          end
        end
      end
      ST_NEXT: begin
        if (col_last) begin
          c_q <= '0;
          if (row_last) begin
            r_q    <= '0;
            pass_q <= pass_q + 4'd1;
          end else begin
            r_q <= r_q + 10'd1;
          end
        end else begin
          c_q <= c_q + 10'd1;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_done_q;

  // checks
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0)
    else $error("done word carries pixel data");
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == ST_IDLE)
    else $error("input taken while a run is busy");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> dcnt_q < 5'(DivSteps))
    else $error("divider ran past its step count");
endmodule
